### hw/rtl/mspt_pkg.sv
// ----------------------------------------------------------------------------
// mspt_pkg
// Shared types and constants of the multichannel solenoid pulse timer:
// channel count, field widths, operation codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package mspt_pkg;

    // Channel count (1 to 4) and fixed field widths
    localparam int NUM_CHANNELS = 4;
    localparam int MASK_W       = 4;
    localparam int CH_W         = 2;
    localparam int OP_W         = 2;
    localparam int WIDTH_W      = 16;

    // Configuration port geometry
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 5;
    localparam int REG_W   = 3;

    // Register reset values
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST = 16'd5;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 16'd1000;
    localparam logic [WIDTH_W-1:0] DEF_WIDTH_RST = 16'd50;

    typedef logic [WIDTH_W-1:0] t_width;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_FIRE_DEF   = 2'd1,
        OP_FIRE_WIDTH = 2'd2,
        OP_ALL_OFF    = 2'd3
    } t_op;

    typedef enum logic [REG_W-1:0] {
        REG_MIN_WIDTH = 3'd0,
        REG_MAX_WIDTH = 3'd1,
        REG_DEF_CH0   = 3'd2,
        REG_DEF_CH1   = 3'd3,
        REG_DEF_CH2   = 3'd4,
        REG_DEF_CH3   = 3'd5
    } t_reg_idx;

endpackage

`default_nettype wire

### hw/rtl/mspt_if.sv
// ----------------------------------------------------------------------------
// mspt_if
// Valid/ready channels of the pulse timer: the command item channel and the
// drive mask result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mspt_cmd_if;
    import mspt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CH_W-1:0]     channel_index;
    logic [WIDTH_W-1:0]  pulse_width;

    modport source (output valid, output operation, output channel_index,
                    output pulse_width, input ready);
    modport sink   (input valid, input operation, input channel_index,
                    input pulse_width, output ready);
endinterface

interface mspt_res_if;
    import mspt_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] drive_mask;

    modport source (output valid, output drive_mask, input ready);
    modport sink   (input valid, input drive_mask, output ready);
endinterface

`default_nettype wire

### hw/rtl/multichannel_solenoid_pulse_timer.sv
// An accepted item passes through the input register and then the drive mask
// register before it is offered as a result.
// Throughput: one item per cycle while results are taken; the input and drive mask
// registers form a two-stage pipe that advances whenever the result is free.
// Reset (synchronous, active low) turns all channels off, clears the counters
// and loads the width registers with their defaults.
// ----------------------------------------------------------------------------
// multichannel_solenoid_pulse_timer
// Retriggerable one-shot per solenoid channel: tick counts down active
// channels, fire loads a clamped width, all off drops every channel.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_solenoid_pulse_timer
    import mspt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    mspt_cmd_if.sink                i_cmd,
    mspt_res_if.source              o_res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    // Configuration registers
    t_width r_min_width;
    t_width r_max_width;
    t_width r_def_width [MASK_W];

    // Input stage
    logic             r_in_valid;
    t_op              r_op;
    logic [CH_W-1:0]  r_ch;
    t_width           r_width;

    // Channel state; the drive bits double as the result payload
    t_width              r_rem [MASK_W];
    t_width              n_rem [MASK_W];
    logic [MASK_W-1:0]   r_drive;
    logic [MASK_W-1:0]   n_drive;
    logic                r_out_valid;

    logic      advance;
    logic      cfg_wr;
    t_reg_idx  reg_idx;
    t_width    sel_width;
    t_width    raised_width;
    t_width    clamped_width;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= MIN_WIDTH_RST;
            r_max_width <= MAX_WIDTH_RST;
            for (int i = 0; i < MASK_W; i++) begin
                r_def_width[i] <= DEF_WIDTH_RST;
            end
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_WIDTH: r_min_width    <= pwdata[WIDTH_W-1:0];
                REG_MAX_WIDTH: r_max_width    <= pwdata[WIDTH_W-1:0];
                REG_DEF_CH0:   r_def_width[0] <= pwdata[WIDTH_W-1:0];
                REG_DEF_CH1:   r_def_width[1] <= pwdata[WIDTH_W-1:0];
                REG_DEF_CH2:   r_def_width[2] <= pwdata[WIDTH_W-1:0];
                REG_DEF_CH3:   r_def_width[3] <= pwdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_MIN_WIDTH: prdata[WIDTH_W-1:0] = r_min_width;
            REG_MAX_WIDTH: prdata[WIDTH_W-1:0] = r_max_width;
            REG_DEF_CH0:   prdata[WIDTH_W-1:0] = r_def_width[0];
            REG_DEF_CH1:   prdata[WIDTH_W-1:0] = r_def_width[1];
            REG_DEF_CH2:   prdata[WIDTH_W-1:0] = r_def_width[2];
            REG_DEF_CH3:   prdata[WIDTH_W-1:0] = r_def_width[3];
            default: ;
        endcase
    end

    // Pipe control: advance when the result register is free or taken
    assign advance     = !r_out_valid || o_res.ready;
    assign i_cmd.ready = !r_in_valid || advance;

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_op    <= t_op'(i_cmd.operation);
            r_ch    <= i_cmd.channel_index;
            r_width <= i_cmd.pulse_width;
        end
    end

    // Pick the width, raise to the minimum, then lower to the maximum
    always_comb begin
        sel_width     = (r_op == OP_FIRE_DEF) ? r_def_width[r_ch] : r_width;
        raised_width  = (sel_width < r_min_width) ? r_min_width : sel_width;
        clamped_width = (raised_width > r_max_width) ? r_max_width : raised_width;
    end

    // Per-channel next state
    for (genvar g = 0; g < MASK_W; g++) begin : g_ch
        if (g < NUM_CHANNELS) begin : g_act
            always_comb begin
                n_rem[g]   = r_rem[g];
                n_drive[g] = r_drive[g];
                case (r_op)
                    OP_TICK: begin
                        if (r_drive[g]) begin
                            if (r_rem[g] <= t_width'(1)) begin
                                n_rem[g]   = '0;
                                n_drive[g] = 1'b0;
                            end else begin
                                n_rem[g] = r_rem[g] - t_width'(1);
                            end
                        end
                    end
                    OP_FIRE_DEF, OP_FIRE_WIDTH: begin
                        if (r_ch == CH_W'(g)) begin
                            n_rem[g]   = clamped_width;
                            n_drive[g] = 1'b1;
                        end
                    end
                    OP_ALL_OFF: begin
                        n_rem[g]   = '0;
                        n_drive[g] = 1'b0;
                    end
                    default: ;
                endcase
            end
        end else begin : g_off
            // Hold channels beyond the channel count off
            assign n_rem[g]   = '0;
            assign n_drive[g] = 1'b0;
        end
    end

    // Update channel state and the result as the item leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_drive     <= '0;
            for (int i = 0; i < MASK_W; i++) begin
                r_rem[i] <= '0;
            end
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_drive <= n_drive;
                for (int i = 0; i < MASK_W; i++) begin
                    r_rem[i] <= n_rem[i];
                end
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.drive_mask = r_drive;

endmodule

`default_nettype wire
